// ----- src/wsr_pkg.sv -----
// Shared constants, codes and control types of the workout sample recorder.
package wsr_pkg;

	// Sample buffer size and field widths.
	localparam int BUFFER_DEPTH = 7200;
	localparam int KIND_W       = 2;
	localparam int STATUS_W     = 2;
	localparam int IDX_W        = 13;
	localparam int POWER_W      = 18;
	localparam int PACE_W       = 18;
	localparam int DIST_W       = 24;
	localparam int RATE_W       = 12;
	localparam int PULSE_W      = 8;
	localparam int SAT_W        = 16;
	localparam int PSUM_W       = 21;
	localparam int RSUM_W       = 25;
	localparam int CNT_W        = 13;
	localparam int NUM_W        = 20;

	// Velocity numerator and the pace bound (9999 s in 1/16 s units).
	localparam logic [NUM_W-1:0]  VEL_NUMERATOR = 20'd800000;
	localparam logic [PACE_W-1:0] PACE_LIMIT    = 18'd159984;
	localparam logic [SAT_W-1:0]  SAT16         = 16'hFFFF;

	// Serial schedule: the distance subtractor sets the length of a run.
	localparam int SERIAL_STEPS = DIST_W;
	localparam int DIV_STEPS    = NUM_W;
	localparam int STEP_W       = $clog2(SERIAL_STEPS);

	// Command kinds.
	localparam logic [KIND_W-1:0] KIND_START  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_END    = 2'd2;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NO_SESSION = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL       = 2'd2;

	// Input tdata layout.
	localparam int IN_DATA_W   = 80;
	localparam int IN_POWER_LO = 0;
	localparam int IN_PACE_LO  = IN_POWER_LO + POWER_W;
	localparam int IN_DIST_LO  = IN_PACE_LO + PACE_W;
	localparam int IN_RATE_LO  = IN_DIST_LO + DIST_W;
	localparam int IN_PULSE_LO = IN_RATE_LO + RATE_W;

	// Output tdata layout.
	localparam int OUT_DATA_W   = 152;
	localparam int OUT_IDX_LO   = 0;
	localparam int OUT_POWER_LO = OUT_IDX_LO + IDX_W;
	localparam int OUT_VEL_LO   = OUT_POWER_LO + SAT_W;
	localparam int OUT_PULSE_LO = OUT_VEL_LO + SAT_W;
	localparam int OUT_DSTEP_LO = OUT_PULSE_LO + PULSE_W;
	localparam int OUT_PEAK_LO  = OUT_DSTEP_LO + SAT_W;
	localparam int OUT_PSUM_LO  = OUT_PEAK_LO + PULSE_W;
	localparam int OUT_PCNT_LO  = OUT_PSUM_LO + PSUM_W;
	localparam int OUT_RSUM_LO  = OUT_PCNT_LO + CNT_W;
	localparam int OUT_RCNT_LO  = OUT_RSUM_LO + RSUM_W;
	localparam int OUT_USED_W   = OUT_RCNT_LO + CNT_W;

	// Control of the serial units.
	typedef struct packed {
		logic load;
		logic sub_en;
		logic div_en;
	} wsr_ctrl_t;

	// State update requests to the session registers.
	typedef struct packed {
		logic start;
		logic close;
		logic sample;
	} wsr_commit_t;

endpackage

// ----- src/workout_sample_recorder.sv -----
// Top level of the workout sample recorder: command decode, serial schedule and result register.
//
// Channel  Direction  tdata                                      tuser
// s_*      in         power, pace, distance, stroke rate, pulse  kind
// m_*      out        index, power, velocity, pulse, dist step,  status
//                     peak, pulse total/count, rate total/count
//
// Transactions do not overlap: s_tready falls on an acceptance and rises once the result is loaded.
// The steps are: accept the command, run the bit-serial distance subtractor (which the
// 20-step velocity divider runs alongside), and load the result register.
// Reset clears the session state, the control state and the result valid flag.
// A result waiting on m_tready holds only the final load; the next transaction is
// accepted and processed while the previous result still waits.
module workout_sample_recorder (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// power_in[17:0], pace_in[35:18], distance_in[59:36], stroke_rate_in[71:60], pulse_in[79:72]
	input  logic [wsr_pkg::IN_DATA_W-1:0]       s_tdata,
	// kind[1:0]
	input  logic [wsr_pkg::KIND_W-1:0]          s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// sample_index[12:0], power_out[28:13], velocity_out[44:29], pulse_out[52:45],
	// distance_step[68:53], pulse_peak[76:69], pulse_total[97:77], pulse_samples[110:98],
	// rate_total[135:111], rate_samples[148:136], zero fill[151:149]
	output logic [wsr_pkg::OUT_DATA_W-1:0]      m_tdata,
	// status[1:0]
	output logic [wsr_pkg::STATUS_W-1:0]        m_tuser
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]                         state_q;
	logic [wsr_pkg::STEP_W-1:0]         step_q;
	logic                               accept;
	logic                               last_step;
	logic                               out_load;
	wsr_pkg::wsr_ctrl_t                 ctrl;
	wsr_pkg::wsr_commit_t               commit;

	logic [wsr_pkg::KIND_W-1:0]         kind_q;
	logic [wsr_pkg::STATUS_W-1:0]       status_q;
	logic                               rec_ok_q;
	logic [wsr_pkg::IDX_W-1:0]          idx_q;
	logic [wsr_pkg::POWER_W-1:0]        power_q;
	logic [wsr_pkg::DIST_W-1:0]         dist_q;
	logic [wsr_pkg::RATE_W-1:0]         rate_q;
	logic [wsr_pkg::PULSE_W-1:0]        pulse_q;

	logic [wsr_pkg::STATUS_W-1:0]       status_next;
	logic                               rec_ok_next;
	logic [wsr_pkg::SAT_W-1:0]          power_clamped;
	logic [wsr_pkg::SAT_W-1:0]          velocity;
	logic [wsr_pkg::SAT_W-1:0]          dist_step;

	logic                               session_open;
	logic [wsr_pkg::IDX_W-1:0]          samples_taken;
	logic [wsr_pkg::DIST_W-1:0]         prev_distance;
	logic [wsr_pkg::PSUM_W-1:0]         pulse_sum;
	logic [wsr_pkg::CNT_W-1:0]          pulse_count;
	logic [wsr_pkg::PULSE_W-1:0]        pulse_max;
	logic [wsr_pkg::RSUM_W-1:0]         rate_sum;
	logic [wsr_pkg::CNT_W-1:0]          rate_count;

	logic                               m_tvalid_q;
	logic [wsr_pkg::OUT_DATA_W-1:0]     m_tdata_q;
	logic [wsr_pkg::STATUS_W-1:0]       m_tuser_q;
	logic [wsr_pkg::OUT_DATA_W-1:0]     out_data;

	// Handshake and schedule decode.
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign last_step = (state_q == ST_RUN) &&
		(step_q == wsr_pkg::STEP_W'(wsr_pkg::SERIAL_STEPS - 1));
	assign out_load  = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);

	always_comb begin
		ctrl.load   = accept;
		ctrl.sub_en = (state_q == ST_RUN);
		ctrl.div_en = (state_q == ST_RUN) &&
			(step_q < wsr_pkg::STEP_W'(wsr_pkg::DIV_STEPS));
		commit.start  = last_step && (kind_q == wsr_pkg::KIND_START);
		commit.close  = last_step && (kind_q == wsr_pkg::KIND_END);
		commit.sample = last_step && rec_ok_q;
	end

	// Status of the command, decided from the session state when it is accepted.
	always_comb begin
		status_next = wsr_pkg::STATUS_OK;
		rec_ok_next = 1'b0;
		case (s_tuser)
			wsr_pkg::KIND_SAMPLE: begin
				if (!session_open) begin
					status_next = wsr_pkg::STATUS_NO_SESSION;
				end else if (samples_taken >= wsr_pkg::IDX_W'(wsr_pkg::BUFFER_DEPTH)) begin
					status_next = wsr_pkg::STATUS_FULL;
				end else begin
					rec_ok_next = 1'b1;
				end
			end
			wsr_pkg::KIND_END: begin
				if (!session_open) begin
					status_next = wsr_pkg::STATUS_NO_SESSION;
				end
			end
			default: begin
				status_next = wsr_pkg::STATUS_OK;
			end
		endcase
	end

	// Control state: idle, serial run, result hand-off.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RUN;
						step_q  <= '0;
					end
				end
				ST_RUN: begin
					if (last_step) begin
						state_q <= ST_DONE;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Command fields held for the length of the run.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= s_tuser;
			status_q <= status_next;
			rec_ok_q <= rec_ok_next;
			idx_q    <= samples_taken;
			power_q  <= s_tdata[wsr_pkg::IN_POWER_LO +: wsr_pkg::POWER_W];
			dist_q   <= s_tdata[wsr_pkg::IN_DIST_LO +: wsr_pkg::DIST_W];
			rate_q   <= s_tdata[wsr_pkg::IN_RATE_LO +: wsr_pkg::RATE_W];
			pulse_q  <= s_tdata[wsr_pkg::IN_PULSE_LO +: wsr_pkg::PULSE_W];
		end
	end

	wsr_vel_div u_vel_div (
		.clk      (clk),
		.ctrl     (ctrl),
		.pace     (s_tdata[wsr_pkg::IN_PACE_LO +: wsr_pkg::PACE_W]),
		.velocity (velocity)
	);

	wsr_dist_sub u_dist_sub (
		.clk       (clk),
		.ctrl      (ctrl),
		.distance  (s_tdata[wsr_pkg::IN_DIST_LO +: wsr_pkg::DIST_W]),
		.prev      (prev_distance),
		.dist_step (dist_step)
	);

	wsr_session u_session (
		.clk           (clk),
		.arst_n        (arst_n),
		.commit        (commit),
		.distance      (dist_q),
		.rate          (rate_q),
		.pulse         (pulse_q),
		.session_open  (session_open),
		.samples_taken (samples_taken),
		.prev_distance (prev_distance),
		.pulse_sum     (pulse_sum),
		.pulse_count   (pulse_count),
		.pulse_max     (pulse_max),
		.rate_sum      (rate_sum),
		.rate_count    (rate_count)
	);

	// Negative power reads as zero, anything above 16 bits saturates.
	always_comb begin
		if (power_q[wsr_pkg::POWER_W-1]) begin
			power_clamped = '0;
		end else if (|power_q[wsr_pkg::POWER_W-2:wsr_pkg::SAT_W]) begin
			power_clamped = wsr_pkg::SAT16;
		end else begin
			power_clamped = power_q[wsr_pkg::SAT_W-1:0];
		end
	end

	// Result packing; the record fields stay zero unless a sample was stored.
	always_comb begin
		out_data = '0;
		if (rec_ok_q) begin
			out_data[wsr_pkg::OUT_IDX_LO +: wsr_pkg::IDX_W]     = idx_q;
			out_data[wsr_pkg::OUT_POWER_LO +: wsr_pkg::SAT_W]   = power_clamped;
			out_data[wsr_pkg::OUT_VEL_LO +: wsr_pkg::SAT_W]     = velocity;
			out_data[wsr_pkg::OUT_PULSE_LO +: wsr_pkg::PULSE_W] = pulse_q;
			out_data[wsr_pkg::OUT_DSTEP_LO +: wsr_pkg::SAT_W]   = dist_step;
		end
		out_data[wsr_pkg::OUT_PEAK_LO +: wsr_pkg::PULSE_W] = pulse_max;
		out_data[wsr_pkg::OUT_PSUM_LO +: wsr_pkg::PSUM_W]  = pulse_sum;
		out_data[wsr_pkg::OUT_PCNT_LO +: wsr_pkg::CNT_W]   = pulse_count;
		out_data[wsr_pkg::OUT_RSUM_LO +: wsr_pkg::RSUM_W]  = rate_sum;
		out_data[wsr_pkg::OUT_RCNT_LO +: wsr_pkg::CNT_W]   = rate_count;
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= out_data;
			m_tuser_q <= status_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// Checks on the schedule and the result contents.
	logic [wsr_pkg::PULSE_W-1:0] chk_peak;
	logic [wsr_pkg::CNT_W-1:0]   chk_pcnt;
	logic [wsr_pkg::OUT_PEAK_LO-1:0] chk_record;

	assign chk_peak   = m_tdata_q[wsr_pkg::OUT_PEAK_LO +: wsr_pkg::PULSE_W];
	assign chk_pcnt   = m_tdata_q[wsr_pkg::OUT_PCNT_LO +: wsr_pkg::CNT_W];
	assign chk_record = m_tdata_q[wsr_pkg::OUT_PEAK_LO-1:0];

	a_accept_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_RUN) && !s_tready)
		else $error("accepted transaction did not start a serial run");

	a_step_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (step_q < wsr_pkg::STEP_W'(wsr_pkg::SERIAL_STEPS)))
		else $error("serial step counter out of range");

	a_record_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser != wsr_pkg::STATUS_OK)) |-> (chk_record == '0))
		else $error("record fields not zero on a failed command");

	a_peak_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((chk_peak == '0) == (chk_pcnt == '0)))
		else $error("pulse peak and pulse count disagree");

endmodule

// ----- src/wsr_vel_div.sv -----
// Bit-serial restoring divider that turns pace into a saturated velocity.
module wsr_vel_div (
	input  logic                            clk,
	input  wsr_pkg::wsr_ctrl_t              ctrl,
	input  logic [wsr_pkg::PACE_W-1:0]      pace,
	output logic [wsr_pkg::SAT_W-1:0]       velocity
);

	logic [wsr_pkg::NUM_W-1:0]  num_q;
	logic [wsr_pkg::NUM_W-1:0]  quo_q;
	logic [wsr_pkg::PACE_W-1:0] rem_q;
	logic [wsr_pkg::PACE_W-1:0] den_q;
	logic [wsr_pkg::PACE_W:0]   trial;
	logic [wsr_pkg::PACE_W:0]   diff;
	logic                       fits;
	logic                       in_range;
	logic                       over;

	// One quotient bit per step: bring down the next numerator bit and try the divisor.
	always_comb begin
		trial = {rem_q, num_q[wsr_pkg::NUM_W-1]};
		diff  = trial - {1'b0, den_q};
		fits  = (trial >= {1'b0, den_q});
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			num_q <= wsr_pkg::VEL_NUMERATOR;
			quo_q <= '0;
			rem_q <= '0;
			den_q <= pace;
		end else if (ctrl.div_en) begin
			num_q <= {num_q[wsr_pkg::NUM_W-2:0], 1'b0};
			quo_q <= {quo_q[wsr_pkg::NUM_W-2:0], fits};
			rem_q <= fits ? diff[wsr_pkg::PACE_W-1:0] : trial[wsr_pkg::PACE_W-1:0];
		end
	end

	// Paces of zero or at or above the limit give no velocity; large quotients saturate.
	always_comb begin
		in_range = (den_q != '0) && (den_q < wsr_pkg::PACE_LIMIT);
		over     = |quo_q[wsr_pkg::NUM_W-1:wsr_pkg::SAT_W];
		if (!in_range) begin
			velocity = '0;
		end else if (over) begin
			velocity = wsr_pkg::SAT16;
		end else begin
			velocity = quo_q[wsr_pkg::SAT_W-1:0];
		end
	end

endmodule

// ----- src/wsr_dist_sub.sv -----
// Bit-serial subtractor for the distance step, least significant bit first.
module wsr_dist_sub (
	input  logic                            clk,
	input  wsr_pkg::wsr_ctrl_t              ctrl,
	input  logic [wsr_pkg::DIST_W-1:0]      distance,
	input  logic [wsr_pkg::DIST_W-1:0]      prev,
	output logic [wsr_pkg::SAT_W-1:0]       dist_step
);

	logic [wsr_pkg::DIST_W-1:0] a_q;
	logic [wsr_pkg::DIST_W-1:0] b_q;
	logic [wsr_pkg::DIST_W-1:0] diff_q;
	logic                       borrow_q;
	logic                       diff_bit;
	logic                       borrow_next;

	// Full subtractor on the low bits of the two shift registers.
	always_comb begin
		diff_bit    = a_q[0] ^ b_q[0] ^ borrow_q;
		borrow_next = (~a_q[0] & b_q[0]) | (~(a_q[0] ^ b_q[0]) & borrow_q);
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			a_q      <= distance;
			b_q      <= prev;
			borrow_q <= 1'b0;
		end else if (ctrl.sub_en) begin
			a_q      <= {1'b0, a_q[wsr_pkg::DIST_W-1:1]};
			b_q      <= {1'b0, b_q[wsr_pkg::DIST_W-1:1]};
			diff_q   <= {diff_bit, diff_q[wsr_pkg::DIST_W-1:1]};
			borrow_q <= borrow_next;
		end
	end

	// A final borrow means the distance went back, which floors at zero.
	always_comb begin
		if (borrow_q) begin
			dist_step = '0;
		end else if (|diff_q[wsr_pkg::DIST_W-1:wsr_pkg::SAT_W]) begin
			dist_step = wsr_pkg::SAT16;
		end else begin
			dist_step = diff_q[wsr_pkg::SAT_W-1:0];
		end
	end

endmodule

// ----- src/wsr_session.sv -----
// Session registers: open flag, sample count, last distance and heart and stroke totals.
module wsr_session (
	input  logic                            clk,
	input  logic                            arst_n,
	input  wsr_pkg::wsr_commit_t            commit,
	input  logic [wsr_pkg::DIST_W-1:0]      distance,
	input  logic [wsr_pkg::RATE_W-1:0]      rate,
	input  logic [wsr_pkg::PULSE_W-1:0]     pulse,
	output logic                            session_open,
	output logic [wsr_pkg::IDX_W-1:0]       samples_taken,
	output logic [wsr_pkg::DIST_W-1:0]      prev_distance,
	output logic [wsr_pkg::PSUM_W-1:0]      pulse_sum,
	output logic [wsr_pkg::CNT_W-1:0]       pulse_count,
	output logic [wsr_pkg::PULSE_W-1:0]     pulse_max,
	output logic [wsr_pkg::RSUM_W-1:0]      rate_sum,
	output logic [wsr_pkg::CNT_W-1:0]       rate_count
);

	logic                         open_q;
	logic [wsr_pkg::IDX_W-1:0]    taken_q;
	logic [wsr_pkg::DIST_W-1:0]   prev_q;
	logic [wsr_pkg::PSUM_W-1:0]   psum_q;
	logic [wsr_pkg::CNT_W-1:0]    pcnt_q;
	logic [wsr_pkg::PULSE_W-1:0]  pmax_q;
	logic [wsr_pkg::RSUM_W-1:0]   rsum_q;
	logic [wsr_pkg::CNT_W-1:0]    rcnt_q;

	// A start opens the session and clears everything else, an end closes, a sample updates the totals.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q  <= 1'b0;
			taken_q <= '0;
			prev_q  <= '0;
			psum_q  <= '0;
			pcnt_q  <= '0;
			pmax_q  <= '0;
			rsum_q  <= '0;
			rcnt_q  <= '0;
		end else if (commit.start) begin
			open_q  <= 1'b1;
			taken_q <= '0;
			prev_q  <= '0;
			psum_q  <= '0;
			pcnt_q  <= '0;
			pmax_q  <= '0;
			rsum_q  <= '0;
			rcnt_q  <= '0;
		end else if (commit.close) begin
			open_q <= 1'b0;
		end else if (commit.sample) begin
			prev_q  <= distance;
			taken_q <= taken_q + 1'b1;
			if (pulse != '0) begin
				psum_q <= psum_q + wsr_pkg::PSUM_W'(pulse);
				pcnt_q <= pcnt_q + 1'b1;
				if (pulse > pmax_q) begin
					pmax_q <= pulse;
				end
			end
			if (rate != '0) begin
				rsum_q <= rsum_q + wsr_pkg::RSUM_W'(rate);
				rcnt_q <= rcnt_q + 1'b1;
			end
		end
	end

	assign session_open  = open_q;
	assign samples_taken = taken_q;
	assign prev_distance = prev_q;
	assign pulse_sum     = psum_q;
	assign pulse_count   = pcnt_q;
	assign pulse_max     = pmax_q;
	assign rate_sum      = rsum_q;
	assign rate_count    = rcnt_q;

endmodule
